/* src/ebf_pkg.sv */
`timescale 1ns / 1ps
package ebf_pkg;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = '0;
   localparam logic [30:0] LIMIT_RESET = 31'd1074;

   // Fixed stage counts of the normalize unit ahead of its divider.
   localparam int UNIT_FRONT_STAGES = 7;
   localparam int SQRT_STAGES       = 32;

   // One step of the digit-by-digit integer square root.
   typedef struct packed {
      logic [63:0] x;
      logic [63:0] r;
   } sqrt_st_type;

   // Three magnitudes and their maximum while they are being scaled.
   typedef struct packed {
      logic [2:0][63:0] m;
      logic [63:0]      mx;
   } nrm_type;

   function automatic sqrt_st_type sqrt_step(input sqrt_st_type st, input int k);
      logic [63:0] bit_v;
      logic [63:0] t;
      sqrt_st_type nx;
      bit_v = 64'd1 << (2 * k);
      t = st.r + bit_v;
      if (st.x >= t) begin
         nx.x = st.x - t;
         nx.r = (st.r >> 1) + bit_v;
      end else begin
         nx.x = st.x;
         nx.r = st.r >> 1;
      end
      return nx;
   endfunction

   // Number of register stages in a normalize unit, from its input register to its result.
   function automatic int unit_lat(input int frac);
      return UNIT_FRONT_STAGES + SQRT_STAGES + frac + 2;
   endfunction

endpackage

/* src/ebf_unit.sv */
`timescale 1ns / 1ps
module ebf_unit #(
   parameter int IN_W = 33,
   parameter int FRAC = 30
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [IN_W-1:0]   vec_in [3],
   output logic signed [31:0]       dir_out [3],
   output logic                     nz_out
);
   import ebf_pkg::*;

   localparam int QB = FRAC + 2;

   // Flag bits: [3] nonzero vector, [2:0] component signs.
   logic [63:0] mag_w [3];
   logic [63:0] mag0_ff [3];
   logic [2:0]  neg0_ff;
   nrm_type     st1_in, st2_in, st3_in, st4_in;
   nrm_type     st1_ff, st2_ff, st3_ff, st4_ff;
   logic [3:0]  flg1_ff, flg2_ff, flg3_ff, flg4_ff, flg5_ff, flg6_ff;
   logic [59:0] sq5_ff [3];
   logic [29:0] m5_ff [3];
   logic [63:0] sum6_ff;
   logic [29:0] m6_ff [3];
   sqrt_st_type sqr_ff [SQRT_STAGES];
   logic [29:0] msq_ff [SQRT_STAGES][3];
   logic [3:0]  flgq_ff [SQRT_STAGES];
   logic [63:0] rem_ff [QB][3];
   logic [QB-1:0] q_ff [QB][3];
   logic [31:0] den_ff [QB];
   logic [3:0]  flgd_ff [QB];

   function automatic nrm_type nrm_step(input nrm_type st, input int s);
      nrm_type nx;
      nx = st;
      if (st.mx >= (64'd1 << (29 + s))) begin
         nx.mx = st.mx >> s;
         for (int i = 0; i < 3; i++) nx.m[i] = st.m[i] >> s;
      end else if ((s < 30) && (st.mx < (64'd1 << (30 - s)))) begin
         nx.mx = st.mx << s;
         for (int i = 0; i < 3; i++) nx.m[i] = st.m[i] << s;
      end
      return nx;
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = vec_in[i][IN_W-1] ? (64'd0 - 64'(vec_in[i])) : 64'(vec_in[i]);
      end
      for (int i = 0; i < 3; i++) st1_in.m[i] = mag0_ff[i];
      st1_in.mx = mag0_ff[0];
      if (mag0_ff[1] > st1_in.mx) st1_in.mx = mag0_ff[1];
      if (mag0_ff[2] > st1_in.mx) st1_in.mx = mag0_ff[2];
      st2_in = nrm_step(nrm_step(st1_ff, 32), 16);
      st3_in = nrm_step(nrm_step(st2_ff, 8), 4);
      st4_in = nrm_step(nrm_step(st3_ff, 2), 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag0_ff[i] <= mag_w[i];
            neg0_ff[i] <= vec_in[i][IN_W-1];
         end
         st1_ff  <= st1_in;
         flg1_ff <= {(st1_in.mx != 64'd0), neg0_ff};
         st2_ff  <= st2_in;
         flg2_ff <= flg1_ff;
         st3_ff  <= st3_in;
         flg3_ff <= flg2_ff;
         st4_ff  <= st4_in;
         flg4_ff <= flg3_ff;
         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= st4_ff.m[i][29:0] * st4_ff.m[i][29:0];
            m5_ff[i]  <= st4_ff.m[i][29:0];
            m6_ff[i]  <= m5_ff[i];
         end
         flg5_ff <= flg4_ff;
         sum6_ff <= 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
         flg6_ff <= flg5_ff;
      end
   end

   // Square root of the sum of squares, one result bit per stage.
   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      sqrt_st_type src;
      logic [29:0] msrc [3];
      logic [3:0]  fsrc;
      if (j == 0) begin : g_first
         assign src  = '{x: sum6_ff, r: 64'd0};
         assign msrc = m6_ff;
         assign fsrc = flg6_ff;
      end else begin : g_next
         assign src  = sqr_ff[j-1];
         assign msrc = msq_ff[j-1];
         assign fsrc = flgq_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sqr_ff[j]  <= sqrt_step(src, SQRT_STAGES - 1 - j);
            msq_ff[j]  <= msrc;
            flgq_ff[j] <= fsrc;
         end
      end
   end

   // Rounded division m * 2^FRAC / L, one quotient bit per stage.
   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [63:0]   rsrc [3];
      logic [QB-1:0] qsrc [3];
      logic [31:0]   dsrc;
      logic [3:0]    fsrc;
      logic [63:0]   rem_in [3];
      logic [QB-1:0] q_in [3];
      logic [63:0]   dsh;
      if (j == 0) begin : g_first
         logic [31:0] len;
         assign len  = sqr_ff[SQRT_STAGES-1].r[31:0];
         assign dsrc = len;
         assign fsrc = flgq_ff[SQRT_STAGES-1];
         for (genvar i = 0; i < 3; i++) begin : g_num
            assign rsrc[i] = (64'(msq_ff[SQRT_STAGES-1][i]) << FRAC) + 64'(len >> 1);
            assign qsrc[i] = '0;
         end
      end else begin : g_next
         assign dsrc = den_ff[j-1];
         assign fsrc = flgd_ff[j-1];
         assign rsrc = rem_ff[j-1];
         assign qsrc = q_ff[j-1];
      end
      assign dsh = 64'(dsrc) << (QB - 1 - j);
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rem_in[i] = rsrc[i];
            q_in[i]   = qsrc[i];
            if (rsrc[i] >= dsh) begin
               rem_in[i] = rsrc[i] - dsh;
               q_in[i][QB-1-j] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            den_ff[j]  <= dsrc;
            flgd_ff[j] <= fsrc;
         end
      end
   end

   assign nz_out = flgd_ff[QB-1][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!flgd_ff[QB-1][3]) begin
            dir_out[i] = '0;
         end else if (flgd_ff[QB-1][i]) begin
            dir_out[i] = 32'd0 - 32'(q_ff[QB-1][i]);
         end else begin
            dir_out[i] = 32'(q_ff[QB-1][i]);
         end
      end
   end

endmodule

/* src/edge_bisector_frame_vector.sv */
`timescale 1ns / 1ps
// Edge bisector frame vector.
// Each beat on the req_ channel carries one edge (corner A, corner B) and two
// apex points in Q16.16. The block forms the corner bisectors at A and B,
// removes their components along the edge, and returns on the rsp_ channel
// the normalized sum of the two as a Q2.30 unit vector. rsp_tuser is set and
// the direction is zero when any vector on the way degenerates.
// The pipeline accepts one beat per cycle while the output is not stalled;
// its depth is set by four normalize units in series, each with a 32-stage
// square root and a UNIT_FRACTION_BITS + 2 stage divider.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is lost.
// Synchronous reset clears every valid bit and loads small_length_limit
// with 1074. The APB port holds small_length_limit at byte address 0 and
// must only be written while no beats are in flight.
module edge_bisector_frame_vector #(
   parameter int COORD_FRACTION_BITS = 16,
   parameter int UNIT_FRACTION_BITS  = 30
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // corner_a_x/y/z, corner_b_x/y/z, apex_one_x/y/z, apex_two_x/y/z, 32 bits each
   input  logic [383:0]                     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // direction_x, direction_y, direction_z, 32 bits each
   output logic [95:0]                      rsp_tdata,
   // frame_status
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ebf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import ebf_pkg::*;

   localparam int LAT  = unit_lat(UNIT_FRACTION_BITS);
   localparam int LLEN = LAT - SQRT_STAGES - 2;

   // Register file.
   logic [30:0]          limit_ff;
   logic [CSR_IDX_W-1:0] csr_idx;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == REG_LIMIT) ? {1'b0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_idx == REG_LIMIT)) begin
         limit_ff <= csr_pwdata[30:0];
      end
   end

   // The whole pipeline moves together whenever the output register can take a beat.
   logic adv;
   logic rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;

   // Input stage: the four corner-to-apex vectors and the edge A to B.
   logic               v_p_ff;
   logic signed [32:0] dv_ff [5][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p_ff <= 1'b0;
      end else if (adv) begin
         v_p_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_ff[0][i] <= 33'($signed(req_tdata[192+32*i +: 32])) -
                           33'($signed(req_tdata[32*i +: 32]));
            dv_ff[1][i] <= 33'($signed(req_tdata[288+32*i +: 32])) -
                           33'($signed(req_tdata[32*i +: 32]));
            dv_ff[2][i] <= 33'($signed(req_tdata[192+32*i +: 32])) -
                           33'($signed(req_tdata[96+32*i +: 32]));
            dv_ff[3][i] <= 33'($signed(req_tdata[288+32*i +: 32])) -
                           33'($signed(req_tdata[96+32*i +: 32]));
            dv_ff[4][i] <= 33'($signed(req_tdata[96+32*i +: 32])) -
                           33'($signed(req_tdata[32*i +: 32]));
         end
      end
   end

   // First layer: unit vectors toward the apexes and along the edge.
   logic signed [31:0] u1 [5][3];
   logic [4:0]         nz1;

   for (genvar k = 0; k < 5; k++) begin : g_l1
      ebf_unit #(.IN_W(33), .FRAC(UNIT_FRACTION_BITS)) u_unit (
         .clock   (clock),
         .en      (adv),
         .vec_in  (dv_ff[k]),
         .dir_out (u1[k]),
         .nz_out  (nz1[k])
      );
   end

   // The edge vector rides alongside the first layer.
   logic [LAT-1:0] v1_ff;
   logic [98:0]    e1_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= '0;
      end else if (adv) begin
         v1_ff <= {v1_ff[LAT-2:0], v_p_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_ff[0] <= {dv_ff[4][2], dv_ff[4][1], dv_ff[4][0]};
         for (int n = 1; n < LAT; n++) e1_ff[n] <= e1_ff[n-1];
      end
   end

   // Bisector sums at both corners.
   logic               v_x_ff;
   logic               bad_x_ff;
   logic signed [32:0] s_x_ff [2][3];
   logic [98:0]        e_x_ff;
   logic [95:0]        ue_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_x_ff <= 1'b0;
      end else if (adv) begin
         v_x_ff <= v1_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad_x_ff <= !(&nz1);
         for (int i = 0; i < 3; i++) begin
            s_x_ff[0][i] <= 33'(u1[0][i]) + 33'(u1[1][i]);
            s_x_ff[1][i] <= 33'(u1[2][i]) + 33'(u1[3][i]);
         end
         e_x_ff  <= e1_ff[LAT-1];
         ue_x_ff <= {u1[4][2], u1[4][1], u1[4][0]};
      end
   end

   // Second layer: normalized bisectors, and in parallel the raw sum lengths.
   logic signed [31:0] b2 [2][3];
   logic [1:0]         nzb;
   logic [63:0]        lsq_ff [2][3];
   logic [63:0]        lsum_ff [2];
   sqrt_st_type        lrt_ff [2][SQRT_STAGES];
   logic [1:0]         short_w;

   for (genvar c = 0; c < 2; c++) begin : g_l2
      logic [32:0] smag [3];

      ebf_unit #(.IN_W(33), .FRAC(UNIT_FRACTION_BITS)) u_unit (
         .clock   (clock),
         .en      (adv),
         .vec_in  (s_x_ff[c]),
         .dir_out (b2[c]),
         .nz_out  (nzb[c])
      );

      for (genvar i = 0; i < 3; i++) begin : g_mag
         assign smag[i] = s_x_ff[c][i][32] ? (33'd0 - s_x_ff[c][i]) : s_x_ff[c][i];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               lsq_ff[c][i] <= smag[i][31:0] * smag[i][31:0];
            end
            lsum_ff[c] <= lsq_ff[c][0] + lsq_ff[c][1] + lsq_ff[c][2];
            lrt_ff[c][0] <= sqrt_step('{x: lsum_ff[c], r: 64'd0}, SQRT_STAGES - 1);
            for (int j = 1; j < SQRT_STAGES; j++) begin
               lrt_ff[c][j] <= sqrt_step(lrt_ff[c][j-1], SQRT_STAGES - 1 - j);
            end
         end
      end

      assign short_w[c] = lrt_ff[c][SQRT_STAGES-1].r < 64'(limit_ff);
   end

   // Carry the short-sum flags, the edge and its unit vector to the layer output.
   logic [LAT-1:0] v2_ff;
   logic [195:0]   side2_ff [LAT];
   logic [1:0]     short_ff [LLEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= '0;
      end else if (adv) begin
         v2_ff <= {v2_ff[LAT-2:0], v_x_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff[0] <= {bad_x_ff, e_x_ff, ue_x_ff};
         for (int n = 1; n < LAT; n++) side2_ff[n] <= side2_ff[n-1];
         short_ff[0] <= short_w;
         for (int n = 1; n < LLEN; n++) short_ff[n] <= short_ff[n-1];
      end
   end

   // Projection onto the edge: dot product, scale, and the off-edge vector.
   logic signed [31:0] ue2 [3];
   logic signed [32:0] e2 [3];

   for (genvar i = 0; i < 3; i++) begin : g_unpack2
      assign ue2[i] = $signed(side2_ff[LAT-1][32*i +: 32]);
      assign e2[i]  = $signed(side2_ff[LAT-1][96+33*i +: 33]);
   end

   logic [3:0]         v_d_ff;
   logic [3:0]         bad_d_ff;
   logic signed [63:0] prod_ff [2][3];
   logic signed [31:0] b_d0_ff [2][3];
   logic signed [31:0] b_d1_ff [2][3];
   logic signed [32:0] e_d0_ff [3];
   logic signed [32:0] e_d1_ff [3];
   logic signed [31:0] s_d1_ff [2];
   logic signed [31:0] s_w [2];
   logic signed [63:0] pe_ff [2][3];
   logic signed [63:0] bsh_ff [2][3];
   logic signed [63:0] d_ff [2][3];

   always_comb begin
      logic signed [63:0] dot;
      logic [63:0]        dmag;
      logic [63:0]        sm;
      for (int c = 0; c < 2; c++) begin
         dot  = prod_ff[c][0] + prod_ff[c][1] + prod_ff[c][2];
         dmag = dot[63] ? (64'd0 - dot) : dot;
         sm   = (dmag + (64'd1 << (UNIT_FRACTION_BITS - 1))) >> UNIT_FRACTION_BITS;
         if (sm > (64'd1 << UNIT_FRACTION_BITS)) sm = 64'd1 << UNIT_FRACTION_BITS;
         s_w[c] = dot[63] ? (32'd0 - sm[31:0]) : sm[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_d_ff <= '0;
      end else if (adv) begin
         v_d_ff <= {v_d_ff[2:0], v2_ff[LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad_d_ff <= {bad_d_ff[2:0], side2_ff[LAT-1][195] | (|short_ff[LLEN-1]) | !(&nzb)};
         for (int i = 0; i < 3; i++) begin
            // The far corner sees the edge and its unit vector reversed.
            prod_ff[0][i] <= b2[0][i] * ue2[i];
            prod_ff[1][i] <= b2[1][i] * (32'sd0 - ue2[i]);
            e_d0_ff[i]    <= e2[i];
            e_d1_ff[i]    <= e_d0_ff[i];
            for (int c = 0; c < 2; c++) begin
               b_d0_ff[c][i] <= b2[c][i];
               b_d1_ff[c][i] <= b_d0_ff[c][i];
            end
            // Both products are taken at the full 64-bit width of the register.
            pe_ff[0][i] <= s_d1_ff[0] * e_d1_ff[i];
            pe_ff[1][i] <= s_d1_ff[1] * (33'sd0 - e_d1_ff[i]);
            for (int c = 0; c < 2; c++) begin
               bsh_ff[c][i] <= 64'(b_d1_ff[c][i]) <<< COORD_FRACTION_BITS;
               d_ff[c][i]   <= pe_ff[c][i] - bsh_ff[c][i];
            end
         end
         s_d1_ff <= s_w;
      end
   end

   // Third layer: unit off-edge vectors at both corners.
   logic signed [31:0] r3 [2][3];
   logic [1:0]         nzr;

   for (genvar c = 0; c < 2; c++) begin : g_l3
      ebf_unit #(.IN_W(64), .FRAC(UNIT_FRACTION_BITS)) u_unit (
         .clock   (clock),
         .en      (adv),
         .vec_in  (d_ff[c]),
         .dir_out (r3[c]),
         .nz_out  (nzr[c])
      );
   end

   logic [LAT-1:0] v3_ff;
   logic [LAT-1:0] bad3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= '0;
      end else if (adv) begin
         v3_ff <= {v3_ff[LAT-2:0], v_d_ff[3]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad3_ff <= {bad3_ff[LAT-2:0], bad_d_ff[3]};
      end
   end

   // Sum of the two off-edge vectors and the final normalize.
   logic               v_y_ff;
   logic               bad_y_ff;
   logic signed [32:0] y_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_y_ff <= 1'b0;
      end else if (adv) begin
         v_y_ff <= v3_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad_y_ff <= bad3_ff[LAT-1] | !(&nzr);
         for (int i = 0; i < 3; i++) y_ff[i] <= 33'(r3[0][i]) + 33'(r3[1][i]);
      end
   end

   logic signed [31:0] r4 [3];
   logic               nz4;

   ebf_unit #(.IN_W(33), .FRAC(UNIT_FRACTION_BITS)) u_final (
      .clock   (clock),
      .en      (adv),
      .vec_in  (y_ff),
      .dir_out (r4),
      .nz_out  (nz4)
   );

   logic [LAT-1:0] v4_ff;
   logic [LAT-1:0] bad4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= '0;
      end else if (adv) begin
         v4_ff <= {v4_ff[LAT-2:0], v_y_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad4_ff <= {bad4_ff[LAT-2:0], bad_y_ff};
      end
   end

   // Output register.
   logic        bad_out;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   assign bad_out = bad4_ff[LAT-1] | !nz4;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= v4_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= bad_out ? 96'd0 : {r4[2], r4[1], r4[0]};
         rsp_tuser_ff <= bad_out;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // A bad frame always carries a zero direction.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 96'd0))
      else $error("bad frame with nonzero direction");

   // A good direction has unit-range components.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (($signed(rsp_tdata[31:0]) <= (32'sd1 <<< UNIT_FRACTION_BITS)) &&
          ($signed(rsp_tdata[31:0]) >= -(32'sd1 <<< UNIT_FRACTION_BITS)) &&
          ($signed(rsp_tdata[63:32]) <= (32'sd1 <<< UNIT_FRACTION_BITS)) &&
          ($signed(rsp_tdata[63:32]) >= -(32'sd1 <<< UNIT_FRACTION_BITS)) &&
          ($signed(rsp_tdata[95:64]) <= (32'sd1 <<< UNIT_FRACTION_BITS)) &&
          ($signed(rsp_tdata[95:64]) >= -(32'sd1 <<< UNIT_FRACTION_BITS))))
      else $error("direction component out of unit range");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
